### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define MVM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MVM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mvm_pkg.sv
// ---------------------------------------------------------------------------
// mvm_pkg
// Types and constants shared by the matrix-vector multiply core.
// ---------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

    // Default largest supported dimension.
    localparam int MVM_MAX_DIM = 256;

    // Fixed field widths.
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 48;
    localparam int DIM_W  = 9;
    localparam int ROW_W  = 8;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Word modes.
    localparam logic MODE_VECTOR = 1'b0;
    localparam logic MODE_MATRIX = 1'b1;

    // Classification of one word, passed from the front to the back.
    typedef struct packed {
        logic             is_mat;
        logic             first_col;
        logic             end_row;
        logic             last_row;
        logic [ROW_W-1:0] row_index;
    } t_mvm_ctrl;

endpackage

`default_nettype wire

### hdl/mvm_ram.sv
// ---------------------------------------------------------------------------
// mvm_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/mvm_front.sv
// ---------------------------------------------------------------------------
// mvm_front
// Accepts words, tracks load pointer, column and row, and classifies them.
// ---------------------------------------------------------------------------
`default_nettype none

module mvm_front #(
    parameter int MAX_DIM = mvm_pkg::MVM_MAX_DIM
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [mvm_pkg::DIM_W-1:0]    i_cfg_data,
    input  wire logic                         i_push,
    input  wire logic                         i_mode,
    output mvm_pkg::t_mvm_ctrl                o_ctrl,
    output logic      [$clog2(MAX_DIM)-1:0]   o_addr
);

    import mvm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int CW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;

    logic [DIM_W-1:0] r_dim;
    logic [AW-1:0]    r_load_ptr;
    logic [AW-1:0]    r_col;
    logic [AW-1:0]    r_row;

    logic [CW-1:0] dim_ext;
    logic [CW-1:0] eff_dim;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] row_inc;
    logic          ptr_wrap;
    logic          end_row;
    logic          last_row;
    logic          is_mat;

    // Effective dimension: zero counts as one, large values saturate.
    always_comb begin
        dim_ext = CW'(r_dim);
        if (dim_ext == '0) begin
            eff_dim = CW'(1);
        end else if (dim_ext > CW'(MAX_DIM)) begin
            eff_dim = CW'(MAX_DIM);
        end else begin
            eff_dim = dim_ext;
        end
    end

    // Next pointer values and the end-of-row and last-row decisions.
    assign ptr_inc  = CW'(r_load_ptr) + CW'(1);
    assign col_inc  = CW'(r_col) + CW'(1);
    assign row_inc  = CW'(r_row) + CW'(1);
    assign ptr_wrap = (ptr_inc >= eff_dim);
    assign end_row  = (col_inc >= eff_dim);
    assign last_row = (row_inc >= eff_dim);
    assign is_mat   = (i_mode == MODE_MATRIX);

    // Dimension register and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= DIM_W'(1);
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            r_dim      <= i_cfg_data;
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_push) begin
            if (!is_mat) begin
                r_load_ptr <= ptr_wrap ? '0 : ptr_inc[AW-1:0];
            end else if (!end_row) begin
                r_col <= col_inc[AW-1:0];
            end else begin
                r_col <= '0;
                r_row <= last_row ? '0 : row_inc[AW-1:0];
            end
        end
    end

    // Classification handed to the queue.
    always_comb begin
        o_ctrl.is_mat    = is_mat;
        o_ctrl.first_col = (r_col == '0);
        o_ctrl.end_row   = end_row;
        o_ctrl.last_row  = last_row;
        o_ctrl.row_index = ROW_W'(r_row);
        o_addr           = is_mat ? r_col : r_load_ptr;
    end

endmodule

`default_nettype wire

### hdl/mvm_queue.sv
// ---------------------------------------------------------------------------
// mvm_queue
// Small first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module mvm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mvm_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mvm_back.sv
// ---------------------------------------------------------------------------
// mvm_back
// Executes queued words: vector store access, multiply, row accumulation.
// ---------------------------------------------------------------------------
`default_nettype none

module mvm_back #(
    parameter int MAX_DIM = mvm_pkg::MVM_MAX_DIM
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_empty,
    input  wire mvm_pkg::t_mvm_ctrl                  i_ctrl,
    input  wire logic        [$clog2(MAX_DIM)-1:0]   i_addr,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]   i_value,
    output logic                                     o_pop,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output logic signed      [mvm_pkg::ACC_W-1:0]    o_row_result,
    output logic             [mvm_pkg::ROW_W-1:0]    o_row_index,
    output logic                                     o_last_row
);

    import mvm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);

    logic                     advance;
    logic                     ram_we;
    logic                     ram_re;
    logic [ELEM_W-1:0]        ram_rdata;

    logic                     r1_valid;
    t_mvm_ctrl                r1_ctrl;
    logic signed [ELEM_W-1:0] r1_value;

    logic                     r2_valid;
    t_mvm_ctrl                r2_ctrl;
    logic signed [PROD_W-1:0] r2_prod;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    logic                     r_out_valid;
    logic signed [ACC_W-1:0]  r_row_result;
    logic [ROW_W-1:0]         r_row_index;
    logic                     r_last_row;

    // The whole back moves together unless a result waits to be taken.
    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop   = advance && !i_empty;
    assign ram_we  = o_pop && !i_ctrl.is_mat;
    assign ram_re  = o_pop && i_ctrl.is_mat;

    // Vector store.
    mvm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_addr[AW-1:0]),
        .i_wdata (i_value),
        .o_rdata (ram_rdata)
    );

    // Stage one: matrix word waits for its vector entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (advance) begin
            r1_valid <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_ctrl  <= i_ctrl;
            r1_value <= i_value;
        end
    end

    // Stage two: Q8.8 by Q8.8 product, exact in Q16.16.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (advance) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_ctrl <= r1_ctrl;
            r2_prod <= r1_value * signed'(ram_rdata);
        end
    end

    // Stage three: row accumulation, restarted at the first column.
    always_comb begin
        if (r2_ctrl.first_col) begin
            n_acc = ACC_W'(r2_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r2_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r2_valid) begin
            r_acc <= n_acc;
        end
    end

    // Output register for finished rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r2_valid && r2_ctrl.end_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r2_valid && r2_ctrl.end_row) begin
            r_row_result <= n_acc;
            r_row_index  <= r2_ctrl.row_index;
            r_last_row   <= r2_ctrl.last_row;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_result = r_row_result;
    assign o_row_index  = r_row_index;
    assign o_last_row   = r_last_row;

endmodule

`default_nettype wire

### hdl/matrix_vector_multiply_core.sv
// ---------------------------------------------------------------------------
// matrix_vector_multiply_core
// Dense square matrix-vector product, Q8.8 inputs, Q32.16 48-bit row sums.
// ---------------------------------------------------------------------------
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall  | i_mode, i_element_value
//  output   | o_out_valid / i_out_stall| o_row_result, o_row_index, o_last_row
//  config   | i_cfg_we                 | i_cfg_data (dimension)
//
// One word is accepted per cycle while the four-entry queue has room; the
// back executes one word per cycle while no stalled result holds it, through
// store read, multiply and accumulate, and registers each finished row sum.
// Reset is synchronous; there is no clearing pass over the vector store.
// A result held in the output register under stall freezes the back, and the
// input stalls once the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_vector_multiply_core #(
    parameter int MAX_DIM = mvm_pkg::MVM_MAX_DIM
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic        [mvm_pkg::DIM_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0] i_element_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed      [mvm_pkg::ACC_W-1:0]  o_row_result,
    output logic             [mvm_pkg::ROW_W-1:0]  o_row_index,
    output logic                                   o_last_row
);

    import mvm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int CTRL_W = $bits(t_mvm_ctrl);
    localparam int QW = CTRL_W + AW + ELEM_W;

    logic                     push;
    logic                     pop;
    logic                     q_full;
    logic                     q_empty;
    t_mvm_ctrl                f_ctrl;
    logic [AW-1:0]            f_addr;
    logic [QW-1:0]            q_wdata;
    logic [QW-1:0]            q_rdata;
    t_mvm_ctrl                b_ctrl;
    logic [AW-1:0]            b_addr;
    logic signed [ELEM_W-1:0] b_value;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    // Front: counters and classification.
    mvm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_mode     (i_mode),
        .o_ctrl     (f_ctrl),
        .o_addr     (f_addr)
    );

    // Queue between front and back.
    assign q_wdata = {f_ctrl, f_addr, i_element_value};

    mvm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_ctrl  = t_mvm_ctrl'(q_rdata[QW-1 -: CTRL_W]);
    assign b_addr  = q_rdata[ELEM_W +: AW];
    assign b_value = signed'(q_rdata[ELEM_W-1:0]);

    // Back: store access, multiply, accumulate, output register.
    mvm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_ctrl       (b_ctrl),
        .i_addr       (b_addr),
        .i_value      (b_value),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_row_result (o_row_result),
        .o_row_index  (o_row_index),
        .o_last_row   (o_last_row)
    );

endmodule

`default_nettype wire

### hdl/mvm_checker.sv
// ---------------------------------------------------------------------------
// mvm_checker
// Port-level checks on the matrix-vector multiply core, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mvm_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic signed [mvm_pkg::ACC_W-1:0]  o_row_result,
    input  wire logic        [mvm_pkg::ROW_W-1:0]  o_row_index,
    input  wire logic                              o_last_row
);

    logic r_after_last;
    logic out_take;

    assign out_take = o_out_valid && !i_out_stall;

    // Remembers that the last result taken closed the final row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b0;
        end else if (out_take) begin
            r_after_last <= o_last_row;
        end
    end

    // A waiting result stays offered and unchanged.
    `MVM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_row_result) && $stable(o_row_index), "result changed while stalled")

    // Reset leaves no result pending.
    `MVM_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result offered after reset")

    // Reset leaves the queue empty, so input is taken at once.
    `MVM_ASSERT_ALWAYS(a_rst_in, i_clk, !i_rst_n |=> !o_in_stall, "input stalled after reset")

    // The row after the final row is row zero again.
    `MVM_ASSERT(a_row_wrap, i_clk, i_rst_n, o_out_valid && r_after_last |-> o_row_index == '0, "row index did not wrap")

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (.*);

`default_nettype wire
